FILE: hw/rtl/mp2x2_pkg.sv
// ----------------------------------------------------------------------------
// mp2x2_pkg
// Shared types and constants of the 2x2 int8 max pooling core: register
// indexes, register reset values and field widths.
// ----------------------------------------------------------------------------
package mp2x2_pkg;

    // Signed tensor element.
    typedef logic signed [7:0] pix_t;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IN_WIDTH      = 3'd0,
        REG_IN_HEIGHT     = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_POOL_STRIDE   = 3'd3,
        REG_OUT_WIDTH     = 3'd4,
        REG_OUT_HEIGHT    = 3'd5
    } cfg_reg_t;

    // Register reset values.
    localparam logic [8:0]  RST_IN_WIDTH      = 9'd8;
    localparam logic [12:0] RST_IN_HEIGHT     = 13'd8;
    localparam logic [10:0] RST_CHANNEL_COUNT = 11'd1;
    localparam logic [1:0]  RST_POOL_STRIDE   = 2'd2;
    localparam logic [8:0]  RST_OUT_WIDTH     = 9'd4;
    localparam logic [12:0] RST_OUT_HEIGHT    = 13'd4;

    // Limits on heights and channel planes.
    localparam logic [12:0] MAX_HEIGHT   = 13'd4096;
    localparam logic [10:0] MAX_CHANNELS = 11'd1024;

endpackage

FILE: hw/rtl/mp2x2_ram.sv
// ----------------------------------------------------------------------------
// mp2x2_ram
// Generic single-clock RAM with one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module mp2x2_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read-first registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/maxpool_2x2_int8_core.sv
// Path: a pixel that closes a window is registered in stage one with the upper-right value read
// from the row store; its result is then loaded into the output register and transfers from there.
// Throughput: one pixel per cycle; the row store reads and writes one entry per transfer,
// and the input stalls only while a finished window waits behind a stalled output.
// Reset: counters, previous pixel and configuration return to their defaults at once;
// the row store is not cleared, since each row is written before the next row reads it.
// ----------------------------------------------------------------------------
// maxpool_2x2_int8_core
// Streaming 2x2 max pooling of a signed 8-bit tensor in raster order with
// stride 1 or 2. The previous row lives in a RAM, the previous pixel and the
// previous upper value in registers.
// ----------------------------------------------------------------------------
module maxpool_2x2_int8_core #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                cfg_wr_en,
    input  logic [mp2x2_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mp2x2_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [7:0]                   pixel,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [7:0]                   max_value,
    output logic                                last_out
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = 14;
    localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);

    // Configuration registers.
    logic [8:0]  in_width_reg;
    logic [12:0] in_height_reg;
    logic [10:0] channel_count_reg;
    logic [1:0]  pool_stride_reg;
    logic [8:0]  out_width_reg;
    logic [12:0] out_height_reg;

    // Position counters and previous pixel.
    logic [CW-1:0] col_count_reg;
    logic [11:0]   row_count_reg;
    logic [9:0]    plane_count_reg;
    mp2x2_pkg::pix_t prev_pixel_reg;

    // Stage one and output stage.
    logic            s1_valid_reg;
    logic            s1_emit_reg;
    logic            s1_last_reg;
    mp2x2_pkg::pix_t s1_pixel_reg;
    mp2x2_pkg::pix_t s1_left_reg;
    mp2x2_pkg::pix_t prev_top_reg;
    logic            out_valid_reg;
    mp2x2_pkg::pix_t max_value_reg;
    logic            last_out_reg;

    logic            accept;
    logic            s1_go;
    mp2x2_pkg::pix_t top_right;

    logic [CMPW-1:0] w_clamped;
    logic [12:0]     h_clamped;
    logic [10:0]     ch_clamped;
    logic            stride2;
    logic [CMPW-1:0] col_ext;
    logic [CMPW-1:0] col_plus1;
    logic [12:0]     row_plus1;
    logic [10:0]     plane_plus1;
    logic [CMPW-1:0] tc;
    logic [12:0]     tr;
    logic [CMPW-1:0] ocol;
    logic [12:0]     orow;
    logic            on_grid;
    logic            emit;
    logic            last;
    mp2x2_pkg::pix_t max_a;
    mp2x2_pkg::pix_t max_b;
    mp2x2_pkg::pix_t max_win;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg      <= mp2x2_pkg::RST_IN_WIDTH;
            in_height_reg     <= mp2x2_pkg::RST_IN_HEIGHT;
            channel_count_reg <= mp2x2_pkg::RST_CHANNEL_COUNT;
            pool_stride_reg   <= mp2x2_pkg::RST_POOL_STRIDE;
            out_width_reg     <= mp2x2_pkg::RST_OUT_WIDTH;
            out_height_reg    <= mp2x2_pkg::RST_OUT_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                mp2x2_pkg::REG_IN_WIDTH:      in_width_reg      <= cfg_data[8:0];
                mp2x2_pkg::REG_IN_HEIGHT:     in_height_reg     <= cfg_data[12:0];
                mp2x2_pkg::REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[10:0];
                mp2x2_pkg::REG_POOL_STRIDE:   pool_stride_reg   <= cfg_data[1:0];
                mp2x2_pkg::REG_OUT_WIDTH:     out_width_reg     <= cfg_data[8:0];
                mp2x2_pkg::REG_OUT_HEIGHT:    out_height_reg    <= cfg_data[12:0];
                default:                      ;
            endcase
        end
    end

    // Handshake: stage one moves on unless it holds a result and the output is full.
    assign s1_go    = !s1_emit_reg || !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_go;
    assign accept   = in_valid && !in_stall;

    // Effective configuration with out-of-range values clamped.
    always_comb
    begin
        if (in_width_reg < 9'd2)
        begin
            w_clamped = CMPW'(2);
        end
        else if (CMPW'(in_width_reg) > MAX_W_C)
        begin
            w_clamped = MAX_W_C;
        end
        else
        begin
            w_clamped = CMPW'(in_width_reg);
        end

        if (in_height_reg < 13'd2)
        begin
            h_clamped = 13'd2;
        end
        else if (in_height_reg > mp2x2_pkg::MAX_HEIGHT)
        begin
            h_clamped = mp2x2_pkg::MAX_HEIGHT;
        end
        else
        begin
            h_clamped = in_height_reg;
        end

        if (channel_count_reg == 11'd0)
        begin
            ch_clamped = 11'd1;
        end
        else if (channel_count_reg > mp2x2_pkg::MAX_CHANNELS)
        begin
            ch_clamped = mp2x2_pkg::MAX_CHANNELS;
        end
        else
        begin
            ch_clamped = channel_count_reg;
        end
    end

    // Stride codes 2 and 3 step by two, the others by one.
    assign stride2 = pool_stride_reg[1];

    // Window test for the pixel at the current position.
    assign col_ext     = CMPW'(col_count_reg);
    assign col_plus1   = col_ext + CMPW'(1);
    assign row_plus1   = 13'(row_count_reg) + 13'd1;
    assign plane_plus1 = 11'(plane_count_reg) + 11'd1;
    assign tc          = col_ext - CMPW'(1);
    assign tr          = 13'(row_count_reg) - 13'd1;
    assign ocol        = stride2 ? (tc >> 1) : tc;
    assign orow        = stride2 ? (tr >> 1) : tr;
    assign on_grid     = !stride2 || (!tc[0] && !tr[0]);

    assign emit = (row_count_reg != 12'd0) && (col_count_reg != '0) && on_grid
               && (orow < out_height_reg) && (ocol < CMPW'(out_width_reg));
    assign last = (plane_plus1 >= ch_clamped)
               && (orow + 13'd1 == out_height_reg)
               && (ocol + CMPW'(1) == CMPW'(out_width_reg));

    // Position counters and previous pixel advance on each input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg   <= '0;
            row_count_reg   <= '0;
            plane_count_reg <= '0;
            prev_pixel_reg  <= '0;
        end
        else if (accept)
        begin
            prev_pixel_reg <= pixel;
            if (col_plus1 >= w_clamped)
            begin
                col_count_reg <= '0;
                if (row_plus1 >= h_clamped)
                begin
                    row_count_reg <= '0;
                    if (plane_plus1 >= ch_clamped)
                    begin
                        plane_count_reg <= '0;
                    end
                    else
                    begin
                        plane_count_reg <= plane_plus1[9:0];
                    end
                end
                else
                begin
                    row_count_reg <= row_plus1[11:0];
                end
            end
            else
            begin
                col_count_reg <= col_plus1[CW-1:0];
            end
        end
    end

    // Row store: the transfer reads the upper-right value of its column and
    // overwrites it with the new pixel in the same cycle.
    mp2x2_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk     (clk),
        .we      (accept),
        .wr_addr (col_count_reg),
        .wr_data (pixel),
        .re      (accept),
        .rd_addr (col_count_reg),
        .rd_data (top_right)
    );

    // Stage one control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            s1_emit_reg  <= emit;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg  <= last;
            s1_pixel_reg <= pixel;
            s1_left_reg  <= prev_pixel_reg;
        end
        // The upper-right value becomes the upper-left value of the next pixel.
        if (s1_valid_reg && s1_go)
        begin
            prev_top_reg <= top_right;
        end
    end

    // Maximum of the four window values.
    always_comb
    begin
        max_a   = (prev_top_reg > top_right) ? prev_top_reg : top_right;
        max_b   = (s1_left_reg > s1_pixel_reg) ? s1_left_reg : s1_pixel_reg;
        max_win = (max_a > max_b) ? max_a : max_b;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_valid_reg && s1_emit_reg && s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_emit_reg && s1_go)
        begin
            max_value_reg <= max_win;
            last_out_reg  <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign max_value = max_value_reg;
    assign last_out  = last_out_reg;

endmodule
